// ===== rtl/per_bin_running_mean_stdev_defines.svh =====
// Assertion macros shared by the per-bin running statistics RTL.
`ifndef PER_BIN_RUNNING_MEAN_STDEV_DEFINES_SVH
`define PER_BIN_RUNNING_MEAN_STDEV_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PBRMS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("per_bin_running_mean_stdev: check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PBRMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("per_bin_running_mean_stdev: check failed");

`endif

// ===== rtl/pbrms_pkg.sv =====
// Shared widths, limits and pipeline side-band types of the running statistics block.
package pbrms_pkg;

    localparam int BIN_W      = 9;
    localparam int REP_W      = 16;
    localparam int K_W        = 17;
    localparam int GAIN_W     = 32;
    localparam int GSQ_W      = 64;
    localparam int PH_W       = 19;
    localparam int PSQ_W      = 36;
    localparam int PMSQ_W     = 37;
    localparam int PDEV_W     = 38;
    localparam int PSPR_W     = 18;
    localparam int CO_W       = 17;
    localparam int CSQ_W      = 33;
    localparam int CMSQ_W     = 34;

    localparam int DIV_STAGES  = 32;
    localparam int ROOT_STAGES = 32;

    localparam logic [PSQ_W-1:0] PSQ_MAX = {PSQ_W{1'b1}};
    localparam logic [CSQ_W-1:0] CSQ_MAX = {CSQ_W{1'b1}};

    // Everything the write-back stage needs besides the quotients.
    typedef struct packed {
        logic [BIN_W-1:0]        bin;
        logic                    first;
        logic                    gdir;
        logic                    gqdir;
        logic                    pdir;
        logic                    pqdir;
        logic                    cdir;
        logic                    cqdir;
        logic [GAIN_W-1:0]       gm;
        logic [GSQ_W-1:0]        gq;
        logic signed [PH_W-1:0]  pm;
        logic [PSQ_W-1:0]        pq;
        logic [CO_W-1:0]         cm;
        logic [CSQ_W-1:0]        cq;
    } upd_side_t;

    // Everything the output stage needs besides the roots.
    typedef struct packed {
        logic [BIN_W-1:0]        bin;
        logic                    first;
        logic [GAIN_W-1:0]       gm;
        logic signed [PH_W-1:0]  pm;
        logic [CO_W-1:0]         cm;
    } out_side_t;

endpackage

// ===== rtl/pbrms_div.sv =====
// Pipelined restoring divider of a W-bit dividend by a 17-bit divisor.
module pbrms_div #(
    parameter int W = 32
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [pbrms_pkg::K_W-1:0] k,
    input  logic [W-1:0]              num,
    output logic [W-1:0]              quot
);

    localparam int NS  = pbrms_pkg::DIV_STAGES;
    localparam int BPS = (W + NS - 1) / NS;
    localparam int DW  = BPS * NS;
    localparam int KW  = pbrms_pkg::K_W;

    logic [DW-1:0] num_reg [NS];
    logic [KW-2:0] rem_reg [NS];
    logic [KW-1:0] k_reg   [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [DW-1:0] num_in;
        logic [KW-2:0] rem_in;
        logic [KW-1:0] k_in;
        logic [DW-1:0] num_next;
        logic [KW-2:0] rem_next;

        if (s == 0) begin : g_first
            assign num_in = DW'(num);
            assign rem_in = '0;
            assign k_in   = k;
        end
        else begin : g_rest
            assign num_in = num_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign k_in   = k_reg[s-1];
        end

        // Each stage retires BPS quotient bits; the quotient shifts in behind the dividend.
        always_comb
        begin
            logic [KW-1:0] t;
            num_next = num_in;
            rem_next = rem_in;
            for (int b = 0; b < BPS; b++)
            begin
                t = {rem_next, num_next[DW-1]};
                num_next = {num_next[DW-2:0], 1'b0};
                if (t >= k_in)
                begin
                    rem_next = (KW-1)'(t - k_in);
                    num_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = t[KW-2:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s] <= num_next;
                rem_reg[s] <= rem_next;
                k_reg[s]   <= k_in;
            end
        end
    end

    assign quot = num_reg[NS-1][W-1:0];

endmodule

// ===== rtl/pbrms_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
module pbrms_sqrt #(
    parameter int W = 64
) (
    input  logic           clk,
    input  logic           en,
    input  logic [W-1:0]   rad,
    output logic [W/2-1:0] root
);

    localparam int NS = pbrms_pkg::ROOT_STAGES;
    localparam int R  = W / 2;

    logic [W-1:0] rad_reg  [NS];
    logic [R:0]   rem_reg  [NS];
    logic [R-1:0] root_reg [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [W-1:0] rad_in;
        logic [R:0]   rem_in;
        logic [R-1:0] root_in;
        logic [W-1:0] rad_next;
        logic [R:0]   rem_next;
        logic [R-1:0] root_next;

        if (s == 0) begin : g_first
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else begin : g_rest
            assign rad_in  = rad_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        if (s < R) begin : g_step
            always_comb
            begin
                logic [R+2:0] t;
                logic [R+2:0] trial;
                t        = {rem_in, rad_in[W-1:W-2]};
                trial    = {1'b0, root_in, 2'b01};
                rad_next = {rad_in[W-3:0], 2'b00};
                if (t >= trial)
                begin
                    rem_next  = (R+1)'(t - trial);
                    root_next = {root_in[R-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = t[R:0];
                    root_next = {root_in[R-2:0], 1'b0};
                end
            end
        end
        else begin : g_hold
            // The root is complete; the remaining stages only delay it.
            assign rad_next  = '0;
            assign rem_next  = '0;
            assign root_next = root_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s]  <= rad_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign root = root_reg[NS-1];

endmodule

// ===== rtl/per_bin_running_mean_stdev.sv =====
// Top level of the per-bin running mean and standard deviation pipeline.
//
// Each accepted word names a frequency bin, a repeat number and one gain, phase
// and coherence sample. Repeat zero restarts the bin: the samples become the
// means, their squares the mean squares, and the spreads are reported as zero.
// Later repeats move each stored mean and mean square toward the new value by
// (value - old)/(n+1), truncated toward zero, and report each mean with
// floor(sqrt(|mean square - mean^2|)). Every word yields exactly one result word,
// in order. The statistics live in six NUM_BINS-deep memories addressed by
// bin_index modulo NUM_BINS; bin_out echoes bin_index. A bin must be started
// with repeat zero before a later repeat reads it, otherwise its results are
// meaningless. The block takes one word per cycle as long as no result is
// stalled and no word targets a bin still in flight. A word whose bin matches
// one of the 35 words between the memory read and the write-back (three front
// stages plus the 32-stage divider) is held until that earlier word has
// written back, so a stream that hits one bin back to back waits out each
// write-back. The read-to-write window is set by the divider, which retires
// one or two quotient bits per stage. A stalled result freezes the whole
// pipeline, and in_stall rises in the same cycle.
module per_bin_running_mean_stdev #(
    parameter int NUM_BINS = 512
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [pbrms_pkg::BIN_W-1:0]            bin_index,
    input  logic [pbrms_pkg::REP_W-1:0]            repeat_number,
    input  logic [pbrms_pkg::GAIN_W-1:0]           gain_sample,
    input  logic signed [pbrms_pkg::PH_W-1:0]      phase_sample,
    input  logic [pbrms_pkg::CO_W-1:0]             coherence_sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [pbrms_pkg::BIN_W-1:0]            bin_out,
    output logic [pbrms_pkg::GAIN_W-1:0]           gain_mean,
    output logic [pbrms_pkg::GAIN_W-1:0]           gain_spread,
    output logic signed [pbrms_pkg::PH_W-1:0]      phase_mean,
    output logic [pbrms_pkg::PSPR_W-1:0]           phase_spread,
    output logic [pbrms_pkg::CO_W-1:0]             coherence_mean,
    output logic [pbrms_pkg::CO_W-1:0]             coherence_spread
);

`include "per_bin_running_mean_stdev_defines.svh"

    localparam int IW     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int DS     = pbrms_pkg::DIV_STAGES;
    localparam int RS     = pbrms_pkg::ROOT_STAGES;
    localparam int BW     = pbrms_pkg::BIN_W;
    localparam int KW     = pbrms_pkg::K_W;
    localparam int GW     = pbrms_pkg::GAIN_W;
    localparam int GQW    = pbrms_pkg::GSQ_W;
    localparam int PW     = pbrms_pkg::PH_W;
    localparam int PQW    = pbrms_pkg::PSQ_W;
    localparam int PMQW   = pbrms_pkg::PMSQ_W;
    localparam int PDW    = pbrms_pkg::PDEV_W;
    localparam int CW     = pbrms_pkg::CO_W;
    localparam int CQW    = pbrms_pkg::CSQ_W;
    localparam int CMQW   = pbrms_pkg::CMSQ_W;
    // Reciprocal of NUM_BINS in 32 fraction bits, truncated plus one; exact for 9-bit bins.
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / NUM_BINS + 64'd1);
    localparam logic [16:0] NB17  = 17'(NUM_BINS);

    // Pipeline advance: everything moves unless a finished result is held.
    logic en;
    logic accept;
    logic bin_hit;

    // Bin to memory index.
    logic [41:0]   quot_prod;
    logic [9:0]    bin_quot;
    logic [26:0]   quot_mul;
    logic [BW-1:0] bin_mod;
    logic [IW-1:0] in_idx;
    logic [PW-1:0] ph_bits;
    logic [PW-1:0] in_pabs;

    // Statistics memories.
    logic [GW-1:0]        gm_mem [NUM_BINS];
    logic [GQW-1:0]       gq_mem [NUM_BINS];
    logic signed [PW-1:0] pm_mem [NUM_BINS];
    logic [PQW-1:0]       pq_mem [NUM_BINS];
    logic [CW-1:0]        cm_mem [NUM_BINS];
    logic [CQW-1:0]       cq_mem [NUM_BINS];

    logic [GW-1:0]        rd_gm_reg;
    logic [GQW-1:0]       rd_gq_reg;
    logic signed [PW-1:0] rd_pm_reg;
    logic [PQW-1:0]       rd_pq_reg;
    logic [CW-1:0]        rd_cm_reg;
    logic [CQW-1:0]       rd_cq_reg;

    // Stage 1: captured word.
    logic                 v1_reg;
    logic [BW-1:0]        bin1_reg;
    logic [IW-1:0]        idx1_reg;
    logic [15:0]          rep1_reg;
    logic [GW-1:0]        g1_reg;
    logic signed [PW-1:0] p1_reg;
    logic [PW-1:0]        pabs1_reg;
    logic [CW-1:0]        c1_reg;

    // Stage 2: squared samples and old statistics.
    logic                 v2_reg;
    logic [BW-1:0]        bin2_reg;
    logic [IW-1:0]        idx2_reg;
    logic                 first2_reg;
    logic [KW-1:0]        k2_reg;
    logic [GW-1:0]        g2_reg;
    logic [GQW-1:0]       gsq2_reg;
    logic signed [PW-1:0] p2_reg;
    logic [PQW-1:0]       psq2_reg;
    logic [CW-1:0]        c2_reg;
    logic [CQW-1:0]       csq2_reg;
    logic [GW-1:0]        ogm2_reg;
    logic [GQW-1:0]       ogq2_reg;
    logic signed [PW-1:0] opm2_reg;
    logic [PQW-1:0]       opq2_reg;
    logic [CW-1:0]        ocm2_reg;
    logic [CQW-1:0]       ocq2_reg;
    logic                 first2_next;
    logic [KW-1:0]        k2_next;
    logic [PW+PW-1:0]     psq_full;
    logic [CMQW-1:0]      csq_full;

    // Stage 3: divider operands.
    logic                  v3_reg;
    logic [IW-1:0]         idx3_reg;
    logic [KW-1:0]         k3_reg;
    pbrms_pkg::upd_side_t  side3_reg;
    pbrms_pkg::upd_side_t  side3_next;
    logic [GW-1:0]         gd3_reg;
    logic [GQW-1:0]        gqd3_reg;
    logic [PW:0]           pd3_reg;
    logic [PQW-1:0]        pqd3_reg;
    logic [CW-1:0]         cd3_reg;
    logic [CQW-1:0]        cqd3_reg;
    logic [GW-1:0]         gd3_next;
    logic [GQW-1:0]        gqd3_next;
    logic [PW:0]           pd3_next;
    logic [PW:0]           ph_diff;
    logic [PQW-1:0]        pqd3_next;
    logic [CW-1:0]         cd3_next;
    logic [CQW-1:0]        cqd3_next;

    // Divider stages.
    logic [DS-1:0]         dv_reg;
    logic [IW-1:0]         didx_reg  [DS];
    pbrms_pkg::upd_side_t  dside_reg [DS];
    pbrms_pkg::upd_side_t  wb;
    logic [GW-1:0]         q_gm;
    logic [GQW-1:0]        q_gq;
    logic [PW:0]           q_pm;
    logic [PQW-1:0]        q_pq;
    logic [CW-1:0]         q_cm;
    logic [CQW-1:0]        q_cq;

    // Write-back values.
    logic [GW-1:0]         gm_next;
    logic [GQW-1:0]        gq_next;
    logic signed [PW-1:0]  pm_next;
    logic [PW-1:0]         pmabs_next;
    logic [PQW-1:0]        pq_next;
    logic [CW-1:0]         cm_next;
    logic [CQW-1:0]        cq_next;

    // Stage 36: updated statistics.
    logic                  v36_reg;
    pbrms_pkg::out_side_t  oside36_reg;
    logic [GQW-1:0]        gq36_reg;
    logic [PW-1:0]         pmabs36_reg;
    logic [PQW-1:0]        pq36_reg;
    logic [CQW-1:0]        cq36_reg;

    // Stage 37: squared means.
    logic                  v37_reg;
    pbrms_pkg::out_side_t  oside37_reg;
    logic [GQW-1:0]        gq37_reg;
    logic [PQW-1:0]        pq37_reg;
    logic [CQW-1:0]        cq37_reg;
    logic [GQW-1:0]        gmsq37_reg;
    logic [PMQW-1:0]       pmsq37_reg;
    logic [CMQW-1:0]       cmsq37_reg;

    // Stage 38: variances.
    logic                  v38_reg;
    pbrms_pkg::out_side_t  oside38_reg;
    logic [GQW-1:0]        gdev38_reg;
    logic [PDW-1:0]        pdev38_reg;
    logic [CMQW-1:0]       cdev38_reg;
    logic [GQW-1:0]        gdev38_next;
    logic [PMQW-1:0]       pdev_abs;
    logic [CMQW-1:0]       cdev38_next;

    // Root stages.
    logic [RS-1:0]         sv_reg;
    pbrms_pkg::out_side_t  sside_reg [RS];
    logic [GW-1:0]         root_g;
    logic [PDW/2-1:0]      root_p;
    logic [CW-1:0]         root_c;

    // Output register.
    logic                  out_valid_reg;
    logic [BW-1:0]         bin_out_reg;
    logic [GW-1:0]         gain_mean_reg;
    logic [GW-1:0]         gain_spread_reg;
    logic signed [PW-1:0]  phase_mean_reg;
    logic [pbrms_pkg::PSPR_W-1:0] phase_spread_reg;
    logic [CW-1:0]         coherence_mean_reg;
    logic [CW-1:0]         coherence_spread_reg;

    // ------------------------------------------------------------------
    // Input side: bin index, phase magnitude and the same-bin interlock.
    // ------------------------------------------------------------------
    assign quot_prod = 42'(bin_index) * 42'(RECIP);
    assign bin_quot  = quot_prod[41:32];
    assign quot_mul  = 27'(bin_quot) * 27'(NB17);
    assign bin_mod   = BW'(27'(bin_index) - quot_mul);
    assign in_idx    = IW'(bin_mod);

    assign ph_bits = phase_sample;
    assign in_pabs = ph_bits[PW-1] ? (~ph_bits + PW'(1)) : ph_bits;

    assign en = !(out_valid_reg && out_stall);

    // A bin may have only one word between the memory read and its write-back.
    always_comb
    begin
        bin_hit = (v1_reg && (idx1_reg == in_idx)) ||
                  (v2_reg && (idx2_reg == in_idx)) ||
                  (v3_reg && (idx3_reg == in_idx));
        for (int i = 0; i < DS; i++)
        begin
            bin_hit = bin_hit || (dv_reg[i] && (didx_reg[i] == in_idx));
        end
    end

    assign in_stall = !en || bin_hit;
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Memories: read at acceptance, written back when a word leaves the divider.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_gm_reg <= gm_mem[in_idx];
            rd_gq_reg <= gq_mem[in_idx];
            rd_pm_reg <= pm_mem[in_idx];
            rd_pq_reg <= pq_mem[in_idx];
            rd_cm_reg <= cm_mem[in_idx];
            rd_cq_reg <= cq_mem[in_idx];
            if (dv_reg[DS-1])
            begin
                gm_mem[didx_reg[DS-1]] <= gm_next;
                gq_mem[didx_reg[DS-1]] <= gq_next;
                pm_mem[didx_reg[DS-1]] <= pm_next;
                pq_mem[didx_reg[DS-1]] <= pq_next;
                cm_mem[didx_reg[DS-1]] <= cm_next;
                cq_mem[didx_reg[DS-1]] <= cq_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Front stages. A restart replaces the old statistics by zero and the
    // divisor by one, so the ordinary update yields the sample itself.
    // ------------------------------------------------------------------
    assign first2_next = (rep1_reg == '0);
    assign k2_next     = first2_next ? KW'(1) : (KW'(rep1_reg) + KW'(1));
    assign psq_full    = (PW+PW)'(pabs1_reg) * (PW+PW)'(pabs1_reg);
    assign csq_full    = CMQW'(c1_reg) * CMQW'(c1_reg);

    always_comb
    begin
        side3_next.bin   = bin2_reg;
        side3_next.first = first2_reg;
        side3_next.gm    = ogm2_reg;
        side3_next.gq    = ogq2_reg;
        side3_next.pm    = opm2_reg;
        side3_next.pq    = opq2_reg;
        side3_next.cm    = ocm2_reg;
        side3_next.cq    = ocq2_reg;

        side3_next.gdir  = (g2_reg < ogm2_reg);
        gd3_next         = side3_next.gdir ? (ogm2_reg - g2_reg) : (g2_reg - ogm2_reg);
        side3_next.gqdir = (gsq2_reg < ogq2_reg);
        gqd3_next        = side3_next.gqdir ? (ogq2_reg - gsq2_reg) : (gsq2_reg - ogq2_reg);

        ph_diff          = {p2_reg[PW-1], p2_reg} - {opm2_reg[PW-1], opm2_reg};
        side3_next.pdir  = ph_diff[PW];
        pd3_next         = side3_next.pdir ? (~ph_diff + (PW+1)'(1)) : ph_diff;
        side3_next.pqdir = (psq2_reg < opq2_reg);
        pqd3_next        = side3_next.pqdir ? (opq2_reg - psq2_reg) : (psq2_reg - opq2_reg);

        side3_next.cdir  = (c2_reg < ocm2_reg);
        cd3_next         = side3_next.cdir ? (ocm2_reg - c2_reg) : (c2_reg - ocm2_reg);
        side3_next.cqdir = (csq2_reg < ocq2_reg);
        cqd3_next        = side3_next.cqdir ? (ocq2_reg - csq2_reg) : (csq2_reg - ocq2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bin1_reg  <= bin_index;
            idx1_reg  <= in_idx;
            rep1_reg  <= repeat_number;
            g1_reg    <= gain_sample;
            p1_reg    <= phase_sample;
            pabs1_reg <= in_pabs;
            c1_reg    <= coherence_sample;

            bin2_reg   <= bin1_reg;
            idx2_reg   <= idx1_reg;
            first2_reg <= first2_next;
            k2_reg     <= k2_next;
            g2_reg     <= g1_reg;
            gsq2_reg   <= GQW'(g1_reg) * GQW'(g1_reg);
            p2_reg     <= p1_reg;
            psq2_reg   <= (psq_full > (PW+PW)'(pbrms_pkg::PSQ_MAX)) ?
                          pbrms_pkg::PSQ_MAX : PQW'(psq_full);
            c2_reg     <= c1_reg;
            csq2_reg   <= (csq_full > CMQW'(pbrms_pkg::CSQ_MAX)) ?
                          pbrms_pkg::CSQ_MAX : CQW'(csq_full);
            ogm2_reg   <= first2_next ? '0 : rd_gm_reg;
            ogq2_reg   <= first2_next ? '0 : rd_gq_reg;
            opm2_reg   <= first2_next ? '0 : rd_pm_reg;
            opq2_reg   <= first2_next ? '0 : rd_pq_reg;
            ocm2_reg   <= first2_next ? '0 : rd_cm_reg;
            ocq2_reg   <= first2_next ? '0 : rd_cq_reg;

            idx3_reg  <= idx2_reg;
            k3_reg    <= k2_reg;
            side3_reg <= side3_next;
            gd3_reg   <= gd3_next;
            gqd3_reg  <= gqd3_next;
            pd3_reg   <= pd3_next;
            pqd3_reg  <= pqd3_next;
            cd3_reg   <= cd3_next;
            cqd3_reg  <= cqd3_next;

            didx_reg[0]  <= idx3_reg;
            dside_reg[0] <= side3_reg;
            for (int i = 1; i < DS; i++)
            begin
                didx_reg[i]  <= didx_reg[i-1];
                dside_reg[i] <= dside_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Dividers: |value - old| / (n+1) for all six statistics in lockstep.
    // ------------------------------------------------------------------
    pbrms_div #(.W(GW)) u_div_gm (
        .clk(clk), .en(en), .k(k3_reg), .num(gd3_reg), .quot(q_gm));
    pbrms_div #(.W(GQW)) u_div_gq (
        .clk(clk), .en(en), .k(k3_reg), .num(gqd3_reg), .quot(q_gq));
    pbrms_div #(.W(PW+1)) u_div_pm (
        .clk(clk), .en(en), .k(k3_reg), .num(pd3_reg), .quot(q_pm));
    pbrms_div #(.W(PQW)) u_div_pq (
        .clk(clk), .en(en), .k(k3_reg), .num(pqd3_reg), .quot(q_pq));
    pbrms_div #(.W(CW)) u_div_cm (
        .clk(clk), .en(en), .k(k3_reg), .num(cd3_reg), .quot(q_cm));
    pbrms_div #(.W(CQW)) u_div_cq (
        .clk(clk), .en(en), .k(k3_reg), .num(cqd3_reg), .quot(q_cq));

    // The quotient is applied toward the sample, so each mean stays in range.
    assign wb         = dside_reg[DS-1];
    assign gm_next    = wb.gdir  ? (wb.gm - q_gm) : (wb.gm + q_gm);
    assign gq_next    = wb.gqdir ? (wb.gq - q_gq) : (wb.gq + q_gq);
    assign pm_next    = wb.pdir  ? (wb.pm - q_pm[PW-1:0]) : (wb.pm + q_pm[PW-1:0]);
    assign pmabs_next = pm_next[PW-1] ? (~pm_next + PW'(1)) : pm_next;
    assign pq_next    = wb.pqdir ? (wb.pq - q_pq) : (wb.pq + q_pq);
    assign cm_next    = wb.cdir  ? (wb.cm - q_cm) : (wb.cm + q_cm);
    assign cq_next    = wb.cqdir ? (wb.cq - q_cq) : (wb.cq + q_cq);

    // ------------------------------------------------------------------
    // Back stages: squared means, absolute variances, then the roots.
    // ------------------------------------------------------------------
    assign gdev38_next = (gq37_reg >= gmsq37_reg) ? (gq37_reg - gmsq37_reg) :
                                                    (gmsq37_reg - gq37_reg);
    assign pdev_abs    = (PMQW'(pq37_reg) >= pmsq37_reg) ?
                         (PMQW'(pq37_reg) - pmsq37_reg) : (pmsq37_reg - PMQW'(pq37_reg));
    assign cdev38_next = (CMQW'(cq37_reg) >= cmsq37_reg) ?
                         (CMQW'(cq37_reg) - cmsq37_reg) : (cmsq37_reg - CMQW'(cq37_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oside36_reg.bin   <= wb.bin;
            oside36_reg.first <= wb.first;
            oside36_reg.gm    <= gm_next;
            oside36_reg.pm    <= pm_next;
            oside36_reg.cm    <= cm_next;
            gq36_reg          <= gq_next;
            pmabs36_reg       <= pmabs_next;
            pq36_reg          <= pq_next;
            cq36_reg          <= cq_next;

            oside37_reg <= oside36_reg;
            gq37_reg    <= gq36_reg;
            pq37_reg    <= pq36_reg;
            cq37_reg    <= cq36_reg;
            gmsq37_reg  <= GQW'(oside36_reg.gm) * GQW'(oside36_reg.gm);
            pmsq37_reg  <= PMQW'(pmabs36_reg) * PMQW'(pmabs36_reg);
            cmsq37_reg  <= CMQW'(oside36_reg.cm) * CMQW'(oside36_reg.cm);

            oside38_reg <= oside37_reg;
            gdev38_reg  <= gdev38_next;
            pdev38_reg  <= PDW'(pdev_abs);
            cdev38_reg  <= cdev38_next;

            sside_reg[0] <= oside38_reg;
            for (int i = 1; i < RS; i++)
            begin
                sside_reg[i] <= sside_reg[i-1];
            end

            // A restart reports zero spread even where its square saturated.
            bin_out_reg          <= sside_reg[RS-1].bin;
            gain_mean_reg        <= sside_reg[RS-1].gm;
            phase_mean_reg       <= sside_reg[RS-1].pm;
            coherence_mean_reg   <= sside_reg[RS-1].cm;
            gain_spread_reg      <= sside_reg[RS-1].first ? '0 : root_g;
            phase_spread_reg     <= sside_reg[RS-1].first ? '0 :
                                    root_p[pbrms_pkg::PSPR_W-1:0];
            coherence_spread_reg <= sside_reg[RS-1].first ? '0 : root_c;
        end
    end

    pbrms_sqrt #(.W(GQW)) u_sqrt_g (
        .clk(clk), .en(en), .rad(gdev38_reg), .root(root_g));
    pbrms_sqrt #(.W(PDW)) u_sqrt_p (
        .clk(clk), .en(en), .rad(pdev38_reg), .root(root_p));
    pbrms_sqrt #(.W(CMQW)) u_sqrt_c (
        .clk(clk), .en(en), .rad(cdev38_reg), .root(root_c));

    // ------------------------------------------------------------------
    // Valid bits travel with the data and hold while the pipeline is frozen.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            dv_reg        <= '0;
            v36_reg       <= 1'b0;
            v37_reg       <= 1'b0;
            v38_reg       <= 1'b0;
            sv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            dv_reg        <= {dv_reg[DS-2:0], v3_reg};
            v36_reg       <= dv_reg[DS-1];
            v37_reg       <= v36_reg;
            v38_reg       <= v37_reg;
            sv_reg        <= {sv_reg[RS-2:0], v38_reg};
            out_valid_reg <= sv_reg[RS-1];
        end
    end

    assign out_valid        = out_valid_reg;
    assign bin_out          = bin_out_reg;
    assign gain_mean        = gain_mean_reg;
    assign gain_spread      = gain_spread_reg;
    assign phase_mean       = phase_mean_reg;
    assign phase_spread     = phase_spread_reg;
    assign coherence_mean   = coherence_mean_reg;
    assign coherence_spread = coherence_spread_reg;

    // Two words of the same bin never sit in the read-to-write window together.
    `PBRMS_ASSERT_IMPL(a_bin_unique_front, v1_reg && v2_reg, idx1_reg != idx2_reg)
    `PBRMS_ASSERT_IMPL(a_bin_unique_wb, v1_reg && dv_reg[DS-1], idx1_reg != didx_reg[DS-1])
    // An accepted word always lands in the first stage.
    `PBRMS_ASSERT_NEXT(a_accept_lands, accept, v1_reg)
    // A held result freezes the valid bits all along the pipeline.
    `PBRMS_ASSERT_NEXT(a_freeze, !en, $stable(v38_reg) && $stable(dv_reg) && out_valid_reg)

endmodule

// ===== tb/per_bin_running_mean_stdev_tb.sv =====
// Self-checking testbench of the per-bin running mean and standard deviation block.
module per_bin_running_mean_stdev_tb;

    localparam int BIN_W  = pbrms_pkg::BIN_W;
    localparam int REP_W  = pbrms_pkg::REP_W;
    localparam int GAIN_W = pbrms_pkg::GAIN_W;
    localparam int GSQ_W  = pbrms_pkg::GSQ_W;
    localparam int PH_W   = pbrms_pkg::PH_W;
    localparam int PSQ_W  = pbrms_pkg::PSQ_W;
    localparam int PSPR_W = pbrms_pkg::PSPR_W;
    localparam int CO_W   = pbrms_pkg::CO_W;
    localparam int CSQ_W  = pbrms_pkg::CSQ_W;

    localparam int NBINS      = 512;
    localparam int MAX_GAP    = 17;
    localparam int LATENCY    = 71;
    localparam int RAND_WORDS = 1500;
    localparam int CYCLE_CAP  = 400000;

    // One result word as the block reports it.
    typedef struct packed {
        logic [BIN_W-1:0]       bin;
        logic [GAIN_W-1:0]      gm;
        logic [GAIN_W-1:0]      gs;
        logic signed [PH_W-1:0] pm;
        logic [PSPR_W-1:0]      ps;
        logic [CO_W-1:0]        cm;
        logic [CO_W-1:0]        cs;
    } stats_word_t;

    int mismatches = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // Mirrors the per-bin statistics and keeps the queue of pending result words.
    class bin_stats_board;
        logic [GAIN_W-1:0]      gain_mean_mem [NBINS];
        logic [GSQ_W-1:0]       gain_sq_mem   [NBINS];
        logic signed [PH_W-1:0] phase_mean_mem[NBINS];
        logic [PSQ_W-1:0]       phase_sq_mem  [NBINS];
        logic [CO_W-1:0]        coh_mean_mem  [NBINS];
        logic [CSQ_W-1:0]       coh_sq_mem    [NBINS];
        stats_word_t            pending[$];
        int                     checked = 0;

        // Moves m toward x by (x - m)/k, truncating toward zero.
        function automatic logic [63:0] nudge(logic [63:0] m, logic [63:0] x, logic [63:0] k);
            if (x >= m) return m + (x - m) / k;
            return m - (m - x) / k;
        endfunction

        function automatic logic [63:0] int_root(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function automatic logic [63:0] dev(logic [63:0] q, logic [63:0] msq);
            return int_root(q >= msq ? q - msq : msq - q);
        endfunction

        function void note_word(logic [BIN_W-1:0] bin, logic [REP_W-1:0] n,
                                logic [GAIN_W-1:0] g, logic signed [PH_W-1:0] p,
                                logic [CO_W-1:0] c);
            int idx;
            logic [63:0] gsq, psq, csq, pabs, k, gq, pq, cm, cq, gm, pmabs;
            longint pm;
            stats_word_t w;
            idx = bin % NBINS;
            pabs = (p < 0) ? -longint'(p) : longint'(p);
            gsq = 64'(g) * 64'(g);
            psq = pabs * pabs;
            if (psq > 64'(pbrms_pkg::PSQ_MAX)) psq = 64'(pbrms_pkg::PSQ_MAX);
            csq = 64'(c) * 64'(c);
            if (csq > 64'(pbrms_pkg::CSQ_MAX)) csq = 64'(pbrms_pkg::CSQ_MAX);
            w = '0;
            if (n == 0) begin
                gm = g; gq = gsq; pm = p; pq = psq; cm = c; cq = csq;
            end
            else begin
                k = 64'(n) + 1;
                gm = nudge(gain_mean_mem[idx], g, k);
                gq = nudge(gain_sq_mem[idx], gsq, k);
                pm = phase_mean_mem[idx];
                pm = pm + (longint'(p) - pm) / longint'(k);
                pq = nudge(phase_sq_mem[idx], psq, k);
                cm = nudge(coh_mean_mem[idx], c, k);
                cq = nudge(coh_sq_mem[idx], csq, k);
                pmabs = pm < 0 ? -pm : pm;
                w.gs = dev(gq, gm * gm);
                w.ps = dev(pq, pmabs * pmabs);
                w.cs = dev(cq, cm * cm);
            end
            gain_mean_mem[idx] = gm;
            gain_sq_mem[idx] = gq;
            phase_mean_mem[idx] = pm;
            phase_sq_mem[idx] = pq;
            coh_mean_mem[idx] = cm;
            coh_sq_mem[idx] = cq;
            w.bin = bin; w.gm = gm; w.pm = pm; w.cm = cm;
            pending.push_back(w);
        endfunction

        task check_word(stats_word_t got);
            stats_word_t want;
            if (pending.size() == 0) begin
                report("unexpected word, bin", got.bin, 0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.bin !== want.bin) report("bin_out", got.bin, want.bin);
            if (got.gm !== want.gm) report("gain_mean", got.gm, want.gm);
            if (got.gs !== want.gs) report("gain_spread", got.gs, want.gs);
            if (got.pm !== want.pm) report("phase_mean", 64'(got.pm), 64'(want.pm));
            if (got.ps !== want.ps) report("phase_spread", got.ps, want.ps);
            if (got.cm !== want.cm) report("coherence_mean", got.cm, want.cm);
            if (got.cs !== want.cs) report("coherence_spread", got.cs, want.cs);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [BIN_W-1:0] bin_index = 0;
    logic [REP_W-1:0] repeat_number = 0;
    logic [GAIN_W-1:0] gain_sample = 0;
    logic signed [PH_W-1:0] phase_sample = 0;
    logic [CO_W-1:0] coherence_sample = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [BIN_W-1:0] bin_out;
    logic [GAIN_W-1:0] gain_mean, gain_spread;
    logic signed [PH_W-1:0] phase_mean;
    logic [PSPR_W-1:0] phase_spread;
    logic [CO_W-1:0] coherence_mean, coherence_spread;

    per_bin_running_mean_stdev #(.NUM_BINS(NBINS)) dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    bin_stats_board board = new();

    // Next repeat number per bin; a bin is only continued after it was started.
    int  next_rep[NBINS];
    bit  started[NBINS];
    int  cycles = 0;
    bit  long_hold = 0;
    bit  sending_done = 0;
    int  sent = 0;
    int  restarts = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("per_bin_running_mean_stdev_tb NOT OK");
            $finish;
        end
    end

    // Sample outputs at the edge where the word is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word('{bin_out, gain_mean, gain_spread, phase_mean,
                               phase_spread, coherence_mean, coherence_spread});
        if (rst_n && in_valid && !in_stall)
            board.note_word(bin_index, repeat_number, gain_sample, phase_sample,
                            coherence_sample);
    end

    // Presents one word and holds it until the block takes it.
    task automatic send_word(input logic [BIN_W-1:0] b, input logic [REP_W-1:0] n,
                             input logic [GAIN_W-1:0] g, input logic signed [PH_W-1:0] p,
                             input logic [CO_W-1:0] c, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, MAX_GAP) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        bin_index <= b;
        repeat_number <= n;
        gain_sample <= g;
        phase_sample <= p;
        coherence_sample <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        started[b] = 1;
        next_rep[b] = (n == 16'hFFFF) ? n : n + 1;
        sent++;
        if (n == 0) restarts++;
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off.
    initial
    begin
        int s;
        @(posedge rst_n);
        forever begin
            if (long_hold) begin
                out_stall <= 1;
                repeat (300) @(posedge clk);
                long_hold = 0;
            end
            if (sent > 800 && sent < 1200) s = 0;
            else s = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_GAP);
            if (s != 0) begin
                out_stall <= 1;
                repeat (s) @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
        end
    end

    function automatic logic signed [PH_W-1:0] rand_phase();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return -19'sd205887;
        if (r == 1) return 19'sd205887;
        if (r == 2) return 19'sh40000;
        return $signed(19'($urandom));
    endfunction

    function automatic logic [CO_W-1:0] rand_coh();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 17'd65536;
        if (r == 1) return 17'h1FFFF;
        if (r < 5) return 17'($urandom);
        return 17'($urandom_range(0, 65536));
    endfunction

    initial
    begin
        int b, n, left;
        logic [GAIN_W-1:0] g;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: start bins at the field extremes, then continue them,
        // including the saturated repeat number, the most negative phase and
        // coherence whose square overflows its store.
        send_word(0, 0, 0, 0, 0, 0);
        send_word(511, 0, 32'hFFFF_FFFF, 19'sd205887, 17'd65536, 0);
        send_word(1, 0, 32'h0001_0000, -19'sd205887, 17'h1FFFF, 0);
        send_word(2, 0, 32'h8000_0000, 19'sh40000, 17'd92682, 0);
        send_word(0, 1, 32'hFFFF_FFFF, 19'sd205887, 17'd65536, 0);
        send_word(511, 1, 0, -19'sd205887, 0, 0);
        send_word(1, 65535, 32'hFFFF_FFFF, 19'sd262143, 17'h1FFFF, 0);
        send_word(2, 3, 1, 19'sh40000, 17'd92681, 0);
        send_word(2, 65534, 32'h5555_5555, 19'sd1, 17'h0AAAA, 0);
        send_word(511, 2, 32'hAAAA_AAAA, -19'sd1, 17'h15555, 0);
        send_word(0, 0, 32'h1234_5678, 19'sd0, 17'd1, 0);
        send_word(0, 1, 32'h1234_5679, 19'sd3, 17'd3, 0);
        send_word(0, 2, 32'h0, -19'sd3, 17'd0, 0);
        send_word(256, 0, 32'h7FFF_FFFF, 19'sd100, 17'd30000, 0);
        send_word(256, 40000, 32'h0, -19'sd100, 17'd65536, 0);

        // Random: mostly continued sequences on a few hot bins, some restarts,
        // with gaps drawn on both sides. A long receiver hold lands mid-run.
        for (int i = 0; i < RAND_WORDS; i++)
        begin
            if (i == 500) long_hold = 1;
            if ($urandom_range(0, 3) == 0) b = $urandom_range(0, 511);
            else b = $urandom_range(0, 7) * 64 + $urandom_range(0, 3);
            if (!started[b] || $urandom_range(0, 19) == 0) n = 0;
            else if ($urandom_range(0, 29) == 0) n = $urandom_range(1, 65535);
            else n = next_rep[b];
            case ($urandom_range(0, 5))
                0: g = 0;
                1: g = 32'hFFFF_FFFF;
                2: g = $urandom_range(0, 32'h0004_0000);
                default: g = $urandom;
            endcase
            send_word(b, n, g, rand_phase(), rand_coh(), i < 800 || i >= 1200);
        end
        in_valid <= 0;

        left = 0;
        while (board.pending.size() != 0 && left < 20000)
        begin
            @(posedge clk);
            left++;
        end
        repeat (LATENCY + 20) @(posedge clk);

        $display("%0d words sent (%0d bin restarts), %0d result words checked",
                 sent, restarts, board.checked);
        if (board.pending.size() != 0) report("words still missing", board.pending.size(), 0);
        if (mismatches == 0)
            $display("per_bin_running_mean_stdev_tb OK");
        else
            $display("per_bin_running_mean_stdev_tb NOT OK");
        $finish;
    end
endmodule
